// ===== sv/rhcc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB / HSV colour conversion: shared definitions
// Default fixed-point formats and the direction code carried in tuser.
// ----------------------------------------------------------------------------
package rhcc_pkg;

    // Fraction bits of a colour component (65536 means 1.0 by default).
    localparam int COMP_FRAC_BITS_DEF = 16;
    // Fraction bits of a hue in degrees.
    localparam int HUE_FRAC_BITS_DEF  = 6;

    typedef enum logic {
        REQ_RGB_TO_HSV = 1'b0,
        REQ_HSV_TO_RGB = 1'b1
    } t_req;

endpackage

// ===== sv/rgb_hsv_color_conversion_unit.sv =====
// ----------------------------------------------------------------------------
// RGB / HSV colour conversion unit
// Converts one pixel per clock, unless the output stalls, between RGB and
// HSV both ways, fully pipelined, with two restoring dividers of one bit per stage.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata: pixel, tuser: direction
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata: hsv and rgb result
//
// A word is taken every cycle while the output does not stall; the path runs
// through four front stages, one divider stage per quotient bit, one
// multiply stage and the output register.
// The throughput is set by the pipeline alone: the dividers are unrolled.
// Reset clears only the valid bits of the stages.
// A stall on the output freezes every stage at once; bubbles inside the
// pipeline still let new words enter while the output register is empty.
//
module rgb_hsv_color_conversion_unit #(
    parameter int COMP_FRAC_BITS = rhcc_pkg::COMP_FRAC_BITS_DEF,
    parameter int HUE_FRAC_BITS  = rhcc_pkg::HUE_FRAC_BITS_DEF,
    localparam int IN_FW  = 5 * (COMP_FRAC_BITS + 1) + HUE_FRAC_BITS + 10,
    localparam int IN_TDW = ((IN_FW + 7) / 8) * 8,
    localparam int OUT_FW = 5 * (COMP_FRAC_BITS + 1) + HUE_FRAC_BITS + 9,
    localparam int OUT_TDW = ((OUT_FW + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // in_red, in_green, in_blue, in_hue, in_sat, in_val
    input  logic [IN_TDW-1:0]  i_s_axis_tdata,
    // req_type
    input  logic               i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // out_hue, out_sat, out_val, out_red, out_green, out_blue
    output logic [OUT_TDW-1:0] o_m_axis_tdata
);

    localparam int CFB   = COMP_FRAC_BITS;
    localparam int HFB   = HUE_FRAC_BITS;
    localparam int CW    = CFB + 1;
    localparam int HIW   = HFB + 10;
    localparam int HOW   = HFB + 9;
    localparam int SXW   = HFB + 6;
    localparam int SEXT  = 60 << HFB;
    localparam int FULLT = 360 << HFB;
    localparam int QW    = (CW > SXW) ? CW : SXW;
    localparam int DW    = QW;
    localparam int NW    = (2 * CW > CW + SXW) ? 2 * CW : CW + SXW;
    localparam int XW    = (NW > DW + QW) ? NW : DW + QW;
    localparam int NSEC  = ((1 << HIW) - 1) / SEXT;
    localparam int SECW  = $clog2(NSEC + 1);
    localparam logic [CW-1:0] ONE = CW'(1) << CFB;

    typedef struct packed {
        logic            req;
        logic            zero;
        logic [1:0]      bsec;
        logic            neg;
        logic [SECW-1:0] sec;
        logic [CW-1:0]   vm;
        logic [2*CW-1:0] pprod;
    } t_side;

    logic adv;
    assign adv = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    // ---------------- stage 1: unpack and clamp ----------------
    logic [CW-1:0]  f_r, f_g, f_b, f_s, f_v;
    logic [HIW-1:0] f_h;
    assign f_r = i_s_axis_tdata[CW-1:0];
    assign f_g = i_s_axis_tdata[2*CW-1:CW];
    assign f_b = i_s_axis_tdata[3*CW-1:2*CW];
    assign f_h = i_s_axis_tdata[3*CW+HIW-1:3*CW];
    assign f_s = i_s_axis_tdata[4*CW+HIW-1:3*CW+HIW];
    assign f_v = i_s_axis_tdata[5*CW+HIW-1:4*CW+HIW];

    logic           r_s1_valid, r_s1_req;
    logic [CW-1:0]  r_s1_r, r_s1_g, r_s1_b, r_s1_s, r_s1_v;
    logic [HIW-1:0] r_s1_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_req <= i_s_axis_tuser;
            r_s1_r   <= (f_r > ONE) ? ONE : f_r;
            r_s1_g   <= (f_g > ONE) ? ONE : f_g;
            r_s1_b   <= (f_b > ONE) ? ONE : f_b;
            r_s1_s   <= (f_s > ONE) ? ONE : f_s;
            r_s1_v   <= (f_v > ONE) ? ONE : f_v;
            r_s1_h   <= f_h;
        end
    end

    // ---------------- stage 2: extremes, sector of the maximum ----------------
    logic [CW-1:0]  n_mx, n_mn, n_ea, n_eb;
    logic [1:0]     n_bsec;
    logic [HIW-1:0] n_hr;

    always_comb begin
        n_mx = r_s1_r;
        n_mn = r_s1_r;
        if (r_s1_g > n_mx) n_mx = r_s1_g;
        if (r_s1_b > n_mx) n_mx = r_s1_b;
        if (r_s1_g < n_mn) n_mn = r_s1_g;
        if (r_s1_b < n_mn) n_mn = r_s1_b;
        if (r_s1_r == n_mx) begin
            n_bsec = 2'd0;
            n_ea   = r_s1_g;
            n_eb   = r_s1_b;
        end else if (r_s1_g == n_mx) begin
            n_bsec = 2'd1;
            n_ea   = r_s1_b;
            n_eb   = r_s1_r;
        end else begin
            n_bsec = 2'd2;
            n_ea   = r_s1_r;
            n_eb   = r_s1_g;
        end
        n_hr = (r_s1_h >= HIW'(FULLT)) ? HIW'(r_s1_h - HIW'(FULLT)) : r_s1_h;
    end

    logic           r_s2_valid, r_s2_req, r_s2_neg;
    logic [1:0]     r_s2_bsec;
    logic [CW-1:0]  r_s2_mx, r_s2_d, r_s2_mag, r_s2_s, r_s2_v;
    logic [HIW-1:0] r_s2_hr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_req  <= r_s1_req;
            r_s2_mx   <= n_mx;
            r_s2_d    <= n_mx - n_mn;
            r_s2_bsec <= n_bsec;
            r_s2_neg  <= n_ea < n_eb;
            r_s2_mag  <= (n_ea >= n_eb) ? n_ea - n_eb : n_eb - n_ea;
            r_s2_hr   <= n_hr;
            r_s2_s    <= r_s1_s;
            r_s2_v    <= r_s1_v;
        end
    end

    // ---------------- stage 3: rgb numerators, hsv sector ----------------
    logic [SECW-1:0] n_sec;
    logic [HIW-1:0]  n_sbase;

    always_comb begin
        n_sec   = '0;
        n_sbase = '0;
        for (int k = 1; k <= NSEC; k++) begin
            if (r_s2_hr >= HIW'(k * SEXT)) begin
                n_sec   = SECW'(k);
                n_sbase = HIW'(k * SEXT);
            end
        end
    end

    logic            r_s3_valid, r_s3_req, r_s3_zero, r_s3_neg;
    logic [1:0]      r_s3_bsec;
    logic [NW-1:0]   r_s3_na, r_s3_nb;
    logic [DW-1:0]   r_s3_da, r_s3_db;
    logic [SECW-1:0] r_s3_sec;
    logic [SXW-1:0]  r_s3_f;
    logic [CW-1:0]   r_s3_s, r_s3_vm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_req  <= r_s2_req;
            r_s3_bsec <= r_s2_bsec;
            r_s3_neg  <= r_s2_neg;
            r_s3_na   <= NW'(r_s2_mag) * NW'(SEXT) + NW'(r_s2_d >> 1);
            r_s3_nb   <= (NW'(r_s2_d) << CFB) + NW'(r_s2_mx >> 1);
            // A zero divisor only occurs for grey pixels whose quotients are unused.
            r_s3_da   <= (r_s2_d == '0) ? DW'(1) : DW'(r_s2_d);
            r_s3_db   <= (r_s2_mx == '0) ? DW'(1) : DW'(r_s2_mx);
            r_s3_sec  <= n_sec;
            r_s3_f    <= SXW'(r_s2_hr - n_sbase);
            r_s3_s    <= r_s2_s;
            if (r_s2_req == rhcc_pkg::REQ_HSV_TO_RGB) begin
                r_s3_zero <= r_s2_s == '0;
                r_s3_vm   <= r_s2_v;
            end else begin
                r_s3_zero <= r_s2_d == '0;
                r_s3_vm   <= r_s2_mx;
            end
        end
    end

    // ---------------- stage 4: hsv products, divider operands ----------------
    logic          r_dv_valid [0:QW];
    logic [NW-1:0] r_dv_na    [0:QW];
    logic [NW-1:0] r_dv_nb    [0:QW];
    logic [DW-1:0] r_dv_da    [0:QW];
    logic [DW-1:0] r_dv_db    [0:QW];
    logic [QW-1:0] r_dv_qa    [0:QW];
    logic [QW-1:0] r_dv_qb    [0:QW];
    t_side         r_dv_sd    [0:QW];

    t_side n_sd;
    always_comb begin
        n_sd.req   = r_s3_req;
        n_sd.zero  = r_s3_zero;
        n_sd.bsec  = r_s3_bsec;
        n_sd.neg   = r_s3_neg;
        n_sd.sec   = r_s3_sec;
        n_sd.vm    = r_s3_vm;
        n_sd.pprod = (2*CW)'(r_s3_vm) * (2*CW)'(ONE - r_s3_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (adv) begin
            r_dv_valid[0] <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_sd[0] <= n_sd;
            r_dv_qa[0] <= '0;
            r_dv_qb[0] <= '0;
            if (r_s3_req == rhcc_pkg::REQ_HSV_TO_RGB) begin
                r_dv_na[0] <= NW'(r_s3_s) * NW'(r_s3_f) + NW'(SEXT / 2);
                r_dv_nb[0] <= NW'(r_s3_s) * NW'(SXW'(SEXT) - r_s3_f) + NW'(SEXT / 2);
                r_dv_da[0] <= DW'(SEXT);
                r_dv_db[0] <= DW'(SEXT);
            end else begin
                r_dv_na[0] <= r_s3_na;
                r_dv_nb[0] <= r_s3_nb;
                r_dv_da[0] <= r_s3_da;
                r_dv_db[0] <= r_s3_db;
            end
        end
    end

    // ---------------- restoring dividers, one quotient bit per stage ----------------
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int BIT = QW - 1 - j;
        logic [XW-1:0] sha, shb;
        logic          ga, gb;

        assign sha = XW'(r_dv_da[j]) << BIT;
        assign shb = XW'(r_dv_db[j]) << BIT;
        assign ga  = XW'(r_dv_na[j]) >= sha;
        assign gb  = XW'(r_dv_nb[j]) >= shb;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j+1] <= 1'b0;
            end else if (adv) begin
                r_dv_valid[j+1] <= r_dv_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_na[j+1] <= ga ? NW'(XW'(r_dv_na[j]) - sha) : r_dv_na[j];
                r_dv_nb[j+1] <= gb ? NW'(XW'(r_dv_nb[j]) - shb) : r_dv_nb[j];
                r_dv_qa[j+1] <= r_dv_qa[j] | (QW'(ga) << BIT);
                r_dv_qb[j+1] <= r_dv_qb[j] | (QW'(gb) << BIT);
                r_dv_da[j+1] <= r_dv_da[j];
                r_dv_db[j+1] <= r_dv_db[j];
                r_dv_sd[j+1] <= r_dv_sd[j];
            end
        end
    end

    // ---------------- post stage: q and t products, rgb hue ----------------
    t_side          dq_sd;
    logic [QW-1:0]  dq_qa, dq_qb;
    logic [HOW-1:0] n_hbase, n_qh, n_hue;

    assign dq_sd = r_dv_sd[QW];
    assign dq_qa = r_dv_qa[QW];
    assign dq_qb = r_dv_qb[QW];

    always_comb begin
        n_hbase = HOW'(dq_sd.bsec) * HOW'(2 * SEXT);
        n_qh    = HOW'(dq_qa);
        if (!dq_sd.neg) begin
            n_hue = n_hbase + n_qh;
        end else if (n_hbase >= n_qh) begin
            n_hue = n_hbase - n_qh;
        end else begin
            // Red sector going below zero wraps round by a full turn.
            n_hue = HOW'(FULLT) - n_qh;
        end
        if (dq_sd.zero) n_hue = '0;
    end

    logic            r_p1_valid;
    t_side           r_p1_sd;
    logic [2*CW-1:0] r_p1_qprod, r_p1_tprod;
    logic [HOW-1:0]  r_p1_hue;
    logic [CW-1:0]   r_p1_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= r_dv_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_sd    <= dq_sd;
            r_p1_qprod <= (2*CW)'(dq_sd.vm) * (2*CW)'(ONE - CW'(dq_qa));
            r_p1_tprod <= (2*CW)'(dq_sd.vm) * (2*CW)'(ONE - CW'(dq_qb));
            r_p1_hue   <= n_hue;
            r_p1_sat   <= dq_sd.zero ? '0 : CW'(dq_qb);
        end
    end

    // ---------------- output register ----------------
    localparam logic [2*CW-1:0] HALF = (2*CW)'(ONE >> 1);

    logic [CW-1:0]  n_p, n_q, n_t, n_v, n_or, n_og, n_ob, n_osat, n_oval;
    logic [HOW-1:0] n_ohue;

    always_comb begin
        n_p = CW'((r_p1_sd.pprod + HALF) >> CFB);
        n_q = CW'((r_p1_qprod + HALF) >> CFB);
        n_t = CW'((r_p1_tprod + HALF) >> CFB);
        n_v = r_p1_sd.vm;
        case (r_p1_sd.sec)
            SECW'(1): begin n_or = n_q; n_og = n_v; n_ob = n_p; end
            SECW'(2): begin n_or = n_p; n_og = n_v; n_ob = n_t; end
            SECW'(3): begin n_or = n_p; n_og = n_q; n_ob = n_v; end
            SECW'(4): begin n_or = n_t; n_og = n_p; n_ob = n_v; end
            SECW'(5): begin n_or = n_v; n_og = n_p; n_ob = n_q; end
            default:  begin n_or = n_v; n_og = n_t; n_ob = n_p; end
        endcase
        if (r_p1_sd.req == rhcc_pkg::REQ_HSV_TO_RGB) begin
            if (r_p1_sd.zero) begin
                n_or = n_v;
                n_og = n_v;
                n_ob = n_v;
            end
            n_ohue = '0;
            n_osat = '0;
            n_oval = '0;
        end else begin
            n_or   = '0;
            n_og   = '0;
            n_ob   = '0;
            n_ohue = r_p1_hue;
            n_osat = r_p1_sat;
            n_oval = r_p1_sd.vm;
        end
    end

    logic                  r_out_valid;
    logic [OUT_TDW-1:0]    r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= OUT_TDW'({n_ob, n_og, n_or, n_oval, n_osat, n_ohue});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // The dividers must end with a remainder below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[QW] |-> (r_dv_na[QW] < NW'(r_dv_da[QW])) &&
                           (r_dv_nb[QW] < NW'(r_dv_db[QW])))
        else $error("divider remainder not below divisor");

    // Hue results stay inside one turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_out_data[HOW-1:0] < HOW'(FULLT))
        else $error("hue out of range");

    // No component or saturation leaves the unit above one.
    a_comp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |-> (n_or <= ONE) && (n_og <= ONE) && (n_ob <= ONE) &&
                       (n_osat <= ONE))
        else $error("component above one");
`endif

endmodule
